@@ rtl/core/gtq_pkg.sv @@
// Shared types, codes and a helper function for the button gesture and tilt qualifier.
`timescale 1ns / 1ps

package gtq_pkg;

    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUTTON_DEBOUNCE = 2'd0,
        CFG_TILT_DEBOUNCE   = 2'd1,
        CFG_LONG_PRESS      = 2'd2,
        CFG_DOUBLE_CLICK    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        BEV_NONE   = 2'd0,
        BEV_SHORT  = 2'd1,
        BEV_LONG   = 2'd2,
        BEV_DOUBLE = 2'd3
    } button_event_t;

    typedef enum logic [2:0] {
        LEV_NONE   = 3'd0,
        LEV_SHORT  = 3'd1,
        LEV_LONG   = 3'd2,
        LEV_DOUBLE = 3'd3,
        LEV_TILT   = 3'd4
    } last_event_t;

    // Settings shared with the datapath.
    typedef struct packed {
        cnt_t button_debounce_ticks;
        cnt_t tilt_debounce_ticks;
        cnt_t long_press_ticks;
        cnt_t double_click_ticks;
    } gtq_cfg_t;

    // Debouncer status for one tick.
    typedef struct packed {
        logic level;
        logic rise;
        logic fall;
    } deb_status_t;

    function automatic cnt_t sat_inc(input cnt_t v);
        return (v == CNT_MAX) ? v : cnt_t'(v + cnt_t'(1));
    endfunction

endpackage

@@ rtl/core/button_gesture_and_tilt_qualifier.sv @@
// Top level: input register, gesture grading logic and result register.
// A single pass carries each word from the input register to the result register.
// Throughput: one word per cycle unless m_ready stalls, set by this single pass; while a
// result waits the input register can take one more word.
// Reset (aresetn low, synchronous) restores default settings, clears all counters,
// debounced levels, the pending click and the stored last event, and empties both stages.
`timescale 1ns / 1ps

module button_gesture_and_tilt_qualifier
    import gtq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wdata,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_button_raw,
    input  logic                 s_tilt_raw,
    input  logic                 s_clear_last,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_button_event,
    output logic                 m_tilt_event,
    output logic [2:0]           m_last_event,
    output logic                 m_button_debounced,
    output logic                 m_tilt_debounced
);

    gtq_cfg_t cfg;

    gtq_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Input register. It is free whenever its word moves on, so a new word
    // can come in every cycle; while the result register is stalled it
    // still holds one more word.
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic in_valid_next;
    logic button_raw_reg;
    logic tilt_raw_reg;
    logic clear_last_reg;
    logic advance;
    logic s_take;

    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            button_raw_reg <= s_button_raw;
            tilt_raw_reg   <= s_tilt_raw;
            clear_last_reg <= s_clear_last;
        end
    end

    // ------------------------------------------------------------------
    // Debouncers. Their state moves one tick each time a word advances.
    // ------------------------------------------------------------------
    deb_status_t button_st;
    deb_status_t tilt_st;

    gtq_debounce u_button_deb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance),
        .raw     (button_raw_reg),
        .limit   (cfg.button_debounce_ticks),
        .status  (button_st)
    );

    gtq_debounce u_tilt_deb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .tick_en (advance),
        .raw     (tilt_raw_reg),
        .limit   (cfg.tilt_debounce_ticks),
        .status  (tilt_st)
    );

    // ------------------------------------------------------------------
    // Gesture grading. The press timer runs while the button was pressed at
    // the start of the tick, and the release timer always runs; both stop
    // at full scale. A debounced press restarts the press timer. A debounced
    // release is long when the press lasted at least the long threshold;
    // otherwise it is a double click if a click is pending, else a short
    // click that arms the pending flag. Short and double releases restart
    // the release timer. The pending flag lapses once the release timer
    // passes the double-click window. A tilt activation is graded last, so
    // it wins the stored last event when both happen in one tick.
    // ------------------------------------------------------------------
    logic          button_level_reg;
    cnt_t          press_length_reg;
    cnt_t          press_length_next;
    cnt_t          since_release_reg;
    cnt_t          since_release_next;
    logic          click_pending_reg;
    logic          click_pending_next;
    last_event_t   stored_event_reg;
    last_event_t   stored_event_next;
    button_event_t bev;
    logic          tev;

    always_comb begin
        press_length_next  = button_level_reg ? sat_inc(press_length_reg) : press_length_reg;
        since_release_next = sat_inc(since_release_reg);
        click_pending_next = click_pending_reg;
        stored_event_next  = clear_last_reg ? LEV_NONE : stored_event_reg;
        bev                = BEV_NONE;
        tev                = 1'b0;

        if (button_st.rise) begin
            press_length_next = '0;
        end else if (button_st.fall) begin
            if (press_length_next >= cfg.long_press_ticks) begin
                bev               = BEV_LONG;
                stored_event_next = LEV_LONG;
            end else begin
                if (click_pending_reg) begin
                    bev                = BEV_DOUBLE;
                    click_pending_next = 1'b0;
                    stored_event_next  = LEV_DOUBLE;
                end else begin
                    bev                = BEV_SHORT;
                    click_pending_next = 1'b1;
                    stored_event_next  = LEV_SHORT;
                end
                since_release_next = '0;
            end
        end

        if (click_pending_next && (since_release_next > cfg.double_click_ticks)) begin
            click_pending_next = 1'b0;
        end

        if (tilt_st.rise) begin
            tev               = 1'b1;
            stored_event_next = LEV_TILT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            button_level_reg  <= 1'b0;
            press_length_reg  <= '0;
            since_release_reg <= '0;
            click_pending_reg <= 1'b0;
            stored_event_reg  <= LEV_NONE;
        end else if (advance) begin
            button_level_reg  <= button_st.level;
            press_length_reg  <= press_length_next;
            since_release_reg <= since_release_next;
            click_pending_reg <= click_pending_next;
            stored_event_reg  <= stored_event_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic          m_valid_reg;
    logic          m_valid_next;
    button_event_t m_button_event_reg;
    logic          m_tilt_event_reg;
    last_event_t   m_last_event_reg;
    logic          m_button_debounced_reg;
    logic          m_tilt_debounced_reg;

    always_comb begin
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_button_event_reg     <= bev;
            m_tilt_event_reg       <= tev;
            m_last_event_reg       <= stored_event_next;
            m_button_debounced_reg <= button_st.level;
            m_tilt_debounced_reg   <= tilt_st.level;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_button_event     = m_button_event_reg;
    assign m_tilt_event       = m_tilt_event_reg;
    assign m_last_event       = m_last_event_reg;
    assign m_button_debounced = m_button_debounced_reg;
    assign m_tilt_debounced   = m_tilt_debounced_reg;

endmodule

@@ rtl/core/gtq_cfg.sv @@
// Configuration register bank for the button gesture and tilt qualifier.
`timescale 1ns / 1ps

module gtq_cfg
    import gtq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_wdata,
    output gtq_cfg_t             cfg
);

    gtq_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.button_debounce_ticks <= cnt_t'(50);
            cfg_reg.tilt_debounce_ticks   <= cnt_t'(100);
            cfg_reg.long_press_ticks      <= cnt_t'(1000);
            cfg_reg.double_click_ticks    <= cnt_t'(400);
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_BUTTON_DEBOUNCE: cfg_reg.button_debounce_ticks <= cfg_wdata;
                CFG_TILT_DEBOUNCE:   cfg_reg.tilt_debounce_ticks   <= cfg_wdata;
                CFG_LONG_PRESS:      cfg_reg.long_press_ticks      <= cfg_wdata;
                CFG_DOUBLE_CLICK:    cfg_reg.double_click_ticks    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/gtq_debounce.sv @@
// Hold-count debouncer for one raw level, advanced once per accepted tick.
`timescale 1ns / 1ps

module gtq_debounce
    import gtq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        tick_en,
    input  logic        raw,
    input  cnt_t        limit,
    output deb_status_t status
);

    logic prev_raw_reg;
    logic stable_reg;
    cnt_t hold_count_reg;
    cnt_t hold_count_next;
    logic change;

    // The counter restarts on any raw edge; the level follows once the
    // raw value has held for more than the limit.
    always_comb begin
        hold_count_next = (raw != prev_raw_reg) ? '0 : sat_inc(hold_count_reg);
        change          = (hold_count_next > limit) && (raw != stable_reg);
        status.level    = change ? raw : stable_reg;
        status.rise     = change && raw;
        status.fall     = change && !raw;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_raw_reg   <= 1'b0;
            stable_reg     <= 1'b0;
            hold_count_reg <= '0;
        end else if (tick_en) begin
            prev_raw_reg   <= raw;
            stable_reg     <= status.level;
            hold_count_reg <= hold_count_next;
        end
    end

endmodule
